FILE: hdl/sxd_pkg.sv
// Shared types and opcode constants for the sprite XOR draw engine.
// Used by every module of the block; it depends on nothing else.
package sxd_pkg;

    // Opcodes of a command beat.
    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // A frame row is always held as 64 bits, column 0 at bit 63.
    localparam int ROW_BITS   = 64;
    // Row addresses travel at the width of the largest display.
    localparam int MAX_ROW_W  = 6;
    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One command beat.
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [3:0] row_index;
        logic [7:0] sprite_bits;
        logic       last_row;
    } cmd_item_t;

    // One response beat.
    typedef struct packed {
        logic                collision;
        logic                sprite_done;
        logic [ROW_BITS-1:0] row_bits;
    } rsp_item_t;

    // A decoded command as it waits in the queue.
    typedef struct packed {
        logic [1:0]           opcode;
        logic [MAX_ROW_W-1:0] row;
        logic [ROW_BITS-1:0]  mask;
        logic                 row_start;
        logic                 last_row;
    } dec_cmd_t;

    // Back-end sequencer states.
    typedef enum logic [0:0] {
        B_IDLE,
        B_EXEC
    } back_state_t;

endpackage

FILE: hdl/sxd_front.sv
// Front end: reduces coordinates modulo the display size and builds the column mask.
// Depends on sxd_pkg.
module sxd_front import sxd_pkg::*;
#(
    parameter int DISPLAY_ROWS    = 32,
    parameter int DISPLAY_COLUMNS = 64
)
(
    input  cmd_item_t cmd,
    output dec_cmd_t  dec
);

    localparam logic [7:0] ROWS_8 = 8'(DISPLAY_ROWS);
    localparam logic [7:0] COLS_8 = 8'(DISPLAY_COLUMNS);

    // Reciprocals scaled by 2^16, rounded up; exact for every 8-bit dividend.
    localparam int RECIP_SHIFT = 16;
    localparam int ROW_RECIP   = ((1 << RECIP_SHIFT) + DISPLAY_ROWS - 1) / DISPLAY_ROWS;
    localparam int COL_RECIP   = ((1 << RECIP_SHIFT) + DISPLAY_COLUMNS - 1) / DISPLAY_COLUMNS;
    localparam logic [13:0] ROW_RECIP_14 = 14'(ROW_RECIP);
    localparam logic [13:0] COL_RECIP_14 = 14'(COL_RECIP);

    // Remainder of an 8-bit value by a constant divisor through its reciprocal.
    function automatic logic [7:0] mod_recip(input logic [7:0]  value,
                                             input logic [7:0]  divisor,
                                             input logic [13:0] recip);
        logic [21:0] prod;
        logic [7:0]  quot;
        logic [15:0] multiple;
        prod     = {14'b0, value} * {8'b0, recip};
        quot     = {2'b00, prod[21:16]};
        multiple = {8'b0, quot} * {8'b0, divisor};
        return value - multiple[7:0];
    endfunction

    logic [7:0]          x_mod;
    logic [7:0]          y_mod;
    logic [7:0]          ri_mod;
    logic [7:0]          row_sum;
    logic [ROW_BITS-1:0] mask;

    // Reduce the coordinates; the row index and the row sum stay below twice the row count.
    always_comb
    begin
        x_mod  = mod_recip(cmd.x_pos, COLS_8, COL_RECIP_14);
        y_mod  = mod_recip(cmd.y_pos, ROWS_8, ROW_RECIP_14);
        ri_mod = {4'b0000, cmd.row_index};
        if (ri_mod >= ROWS_8)
        begin
            ri_mod = ri_mod - ROWS_8;
        end
        row_sum = y_mod + ri_mod;
        if (row_sum >= ROWS_8)
        begin
            row_sum = row_sum - ROWS_8;
        end
    end

    // Place each set sprite bit at its wrapped column.
    always_comb
    begin
        logic [7:0] col;
        mask = '0;
        for (int k = 0; k < 8; k++)
        begin
            col = x_mod + 8'(k);
            if (col >= COLS_8)
            begin
                col = col - COLS_8;
            end
            if (cmd.sprite_bits[7-k])
            begin
                mask[6'd63 - col[5:0]] = 1'b1;
            end
        end
    end

    // Pack the decoded command.
    always_comb
    begin
        dec.opcode    = cmd.opcode;
        dec.row       = (cmd.opcode == OP_READ) ? y_mod[MAX_ROW_W-1:0]
                                                : row_sum[MAX_ROW_W-1:0];
        dec.mask      = mask;
        dec.row_start = (cmd.row_index == 4'd0);
        dec.last_row  = cmd.last_row;
    end

endmodule

FILE: hdl/sxd_queue.sv
// Small FIFO of decoded commands between the front and back ends.
// Depends on sxd_pkg.
module sxd_queue import sxd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  dec_cmd_t push_data,
    output logic     push_ready,
    input  logic     pop,
    output logic     pop_valid,
    output dec_cmd_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dec_cmd_t           slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The fill count never passes the depth, and nothing is popped from an empty queue.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count exceeds depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("pop from empty queue");

    // Nothing is pushed into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("push into full queue");

endmodule

FILE: hdl/sxd_back.sv
// Back end: frame store, read-modify-write of one row, collision flag and response register.
// Depends on sxd_pkg.
module sxd_back import sxd_pkg::*;
#(
    parameter int DISPLAY_ROWS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  dec_cmd_t  q_data,
    output logic      q_pop,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int ROW_W = $clog2(DISPLAY_ROWS);

    back_state_t state_reg, state_next;

    logic [ROW_BITS-1:0]     frame_mem [DISPLAY_ROWS];
    logic [ROW_BITS-1:0]     rd_data_reg;
    logic                    rd_valid_reg;
    logic [DISPLAY_ROWS-1:0] row_valid_reg, row_valid_next;
    dec_cmd_t                work_reg;
    logic                    flag_reg, flag_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_item_t               rsp_reg, rsp_next;

    logic                    commit;
    logic                    out_free;
    logic [ROW_W-1:0]        rd_addr;
    logic [ROW_W-1:0]        wr_addr;
    logic [ROW_BITS-1:0]     row_old;
    logic [ROW_BITS-1:0]     row_new;
    logic                    hit;
    logic                    base_flag;
    logic                    is_draw;
    logic                    is_clear;
    logic                    is_read;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rd_addr   = q_data.row[ROW_W-1:0];
    assign wr_addr   = work_reg.row[ROW_W-1:0];
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        q_pop  = 1'b0;
        commit = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                q_pop = q_valid;
            end
            B_EXEC:
            begin
                commit = out_free;
            end
            default:
            begin
                q_pop  = 1'b0;
                commit = 1'b0;
            end
        endcase
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (commit && is_draw)
        begin
            frame_mem[wr_addr] <= row_new;
        end
        if (q_pop)
        begin
            rd_data_reg <= frame_mem[rd_addr];
            work_reg    <= q_data;
        end
    end

    // Row arithmetic for the command in flight; rows never written read as zero.
    always_comb
    begin
        is_draw   = (work_reg.opcode == OP_DRAW);
        is_clear  = (work_reg.opcode == OP_CLEAR);
        is_read   = (work_reg.opcode == OP_READ);
        row_old   = rd_valid_reg ? rd_data_reg : '0;
        row_new   = row_old ^ work_reg.mask;
        hit       = |(row_old & work_reg.mask);
        base_flag = work_reg.row_start ? 1'b0 : flag_reg;
    end

    // Flag, row-valid bits and response beat.
    always_comb
    begin
        flag_next      = flag_reg;
        row_valid_next = row_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (commit)
        begin
            if (is_draw)
            begin
                flag_next               = base_flag | hit;
                row_valid_next[wr_addr] = 1'b1;
            end
            if (is_clear)
            begin
                row_valid_next = '0;
            end
            rsp_valid_next       = 1'b1;
            rsp_next.collision   = is_draw ? (base_flag | hit) : flag_reg;
            rsp_next.sprite_done = is_draw && work_reg.last_row;
            rsp_next.row_bits    = is_read ? row_old : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            flag_reg      <= 1'b0;
            row_valid_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flag_reg      <= flag_next;
            row_valid_reg <= row_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (q_pop)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // A command waits in execute while the response slot is held.
    a_hold_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EXEC && rsp_valid_reg && !rsp_ready) |=> state_reg == B_EXEC)
        else $error("command left execute with response slot busy");

    // Every commit shows up as a response beat.
    a_commit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid_reg)
        else $error("commit without response beat");

    // A clear leaves no row marked as written.
    a_clear_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && is_clear) |=> row_valid_reg == '0)
        else $error("rows still valid after clear");

    // Pops happen only from idle.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == B_IDLE)
        else $error("queue popped outside idle");

endmodule

FILE: hdl/sprite_xor_draw_engine.sv
// Top level of the sprite XOR draw engine: front end, command queue and back end.
// Depends on sxd_pkg, sxd_front, sxd_queue and sxd_back.
//
// A monochrome frame store of DISPLAY_ROWS rows by DISPLAY_COLUMNS pixels, with an XOR
// sprite row draw that reports collisions, a whole-screen clear and a row readout. Each
// command beat gives exactly one response beat, in order. The front end takes one command
// per cycle while the four-entry queue has room. The back end reads the row from the frame
// store as it pops a command in idle; in execute, once the response slot is free, it
// modifies the row, writes it back for a draw and loads the response register, and only
// then pops the next command. A response waiting to be taken does not hold up the read of
// the next command. Rows carry written bits in flip-flops that reset and clear zero at
// once, so neither needs a sweep of the store and the block is ready out of reset.
module sprite_xor_draw_engine import sxd_pkg::*;
#(
    parameter int DISPLAY_ROWS    = 32,
    parameter int DISPLAY_COLUMNS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    dec_cmd_t dec;
    dec_cmd_t q_data;
    logic     q_valid;
    logic     q_pop;
    logic     push;

    // A valid command beat is pushed whenever the queue has room.
    assign push = cmd_valid && cmd_ready;

    sxd_front #(
        .DISPLAY_ROWS    (DISPLAY_ROWS),
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
    ) u_front (
        .cmd (cmd),
        .dec (dec)
    );

    sxd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (dec),
        .push_ready (cmd_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    sxd_back #(
        .DISPLAY_ROWS (DISPLAY_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
